/* rtl/core/lzss_window_decoder_macros.svh */
// Assertion macros shared by the decoder's RTL files.
// No dependencies; take in by `include after the net type line.
`ifndef LZSS_WINDOW_DECODER_MACROS_SVH
`define LZSS_WINDOW_DECODER_MACROS_SVH

// property that must hold on every clock edge outside reset
`define LZSSWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define LZSSWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lzsswd_pkg.sv */
// Types and constants of the LZSS window decoder.
// No dependencies; imported by every decoder module but lzsswd_ram.
`default_nettype none
package lzsswd_pkg;
   localparam int LEN_W      = 24;
   localparam int HIST_DEPTH = 4096;
   localparam int HIST_AW    = 12;
   localparam int CNT_W      = 5;
   localparam int SUM_W      = 32;

   localparam logic [7:0] SPACE_BYTE = 8'h20;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TRUNC    = 2'd1;
   localparam logic [1:0] ST_ZERODIST = 2'd2;
   localparam logic [1:0] ST_BADSUM   = 2'd3;

   typedef enum logic [2:0] {
      PH_ITEM, PH_REFHI, PH_SUM1, PH_SUM2, PH_SUM3, PH_DROP
   } phase_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_EXEC, BK_DATA, BK_TAIL
   } back_state_type;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_LIT, CMD_COPY, CMD_ZDIST, CMD_CHECK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [7:0]           data;
      logic [HIST_AW-1:0]   distance;
      logic [CNT_W-1:0]     count;
      logic [LEN_W-1:0]     base;
      logic [SUM_W-1:0]     stored;
      logic                 trunc;
      logic                 restart;
   } cmd_type;
endpackage
`default_nettype wire

/* rtl/core/lzsswd_front.sv */
// Front end: accepts compressed words, parses flags, references and checksum.
// Depends on lzsswd_pkg; issues one command per word to the queue.
`default_nettype none
module lzsswd_front import lzsswd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [LEN_W-1:0]  csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_in_byte,
   input  wire logic              req_last_byte,
   input  wire logic              q_full,
   output logic                   q_push,
   output cmd_type                q_cmd
);
   phase_type           phase_ff, phase_in;
   logic [7:0]          flag_bits_ff, flag_bits_in;
   logic [3:0]          flag_index_ff, flag_index_in;
   logic [7:0]          ref_low_ff, ref_low_in;
   logic [LEN_W-1:0]    produced_ff, produced_in;
   logic [23:0]         stored_ff, stored_in;
   logic [LEN_W-1:0]    expected_ff;
   logic [LEN_W-1:0]    room;
   logic [CNT_W-1:0]    ref_len;
   logic [CNT_W-1:0]    ref_n;
   logic [HIST_AW-1:0]  ref_dist;
   logic                status_done;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   assign ref_dist = {req_in_byte[7:4], ref_low_ff};
   assign ref_len  = CNT_W'(req_in_byte[3:0]) + CNT_W'(3);
   assign room     = (produced_ff < expected_ff) ? expected_ff - produced_ff : '0;
   assign ref_n    = (room < LEN_W'(ref_len)) ? room[CNT_W-1:0] : ref_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_ITEM;
         flag_bits_ff  <= '0;
         flag_index_ff <= 4'd8;
         ref_low_ff    <= '0;
         produced_ff   <= '0;
         stored_ff     <= '0;
         expected_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         flag_index_ff <= flag_index_in;
         ref_low_ff    <= ref_low_in;
         produced_ff   <= produced_in;
         stored_ff     <= stored_in;
         if (csr_wr_en) begin
            expected_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      flag_bits_in   = flag_bits_ff;
      flag_index_in  = flag_index_ff;
      ref_low_in     = ref_low_ff;
      produced_in    = produced_ff;
      stored_in      = stored_ff;
      status_done    = 1'b0;
      q_cmd          = '0;
      q_cmd.kind     = CMD_NONE;
      q_cmd.data     = req_in_byte;
      q_cmd.distance = ref_dist;
      q_cmd.base     = produced_ff;
      q_cmd.stored   = {req_in_byte, stored_ff};
      if (q_push) begin
         unique case (phase_ff)
            PH_ITEM: begin
               priority if (produced_ff >= expected_ff) begin
                  stored_in = {16'd0, req_in_byte};
                  phase_in  = PH_SUM1;
               end else if (flag_index_ff >= 4'd8) begin
                  flag_bits_in  = req_in_byte;
                  flag_index_in = '0;
               end else begin
                  flag_index_in = flag_index_ff + 4'd1;
                  if (flag_bits_ff[flag_index_ff[2:0]]) begin
                     q_cmd.kind  = CMD_LIT;
                     produced_in = produced_ff + LEN_W'(1);
                  end else begin
                     ref_low_in = req_in_byte;
                     phase_in   = PH_REFHI;
                  end
               end
            end
            PH_REFHI: begin
               if (ref_dist == '0) begin
                  q_cmd.kind  = CMD_ZDIST;
                  status_done = 1'b1;
                  phase_in    = PH_DROP;
               end else begin
                  q_cmd.kind  = CMD_COPY;
                  q_cmd.count = ref_n;
                  produced_in = produced_ff + LEN_W'(ref_n);
                  phase_in    = PH_ITEM;
               end
            end
            PH_SUM1: begin
               stored_in[15:8] = req_in_byte;
               phase_in        = PH_SUM2;
            end
            PH_SUM2: begin
               stored_in[23:16] = req_in_byte;
               phase_in         = PH_SUM3;
            end
            PH_SUM3: begin
               q_cmd.kind  = CMD_CHECK;
               status_done = 1'b1;
               phase_in    = PH_DROP;
            end
            PH_DROP: begin
               status_done = 1'b1;
            end
            default: begin
               phase_in = PH_ITEM;
            end
         endcase
         if (req_last_byte) begin
            // frame ends here: restart parse state, keep history and length
            q_cmd.trunc   = !status_done;
            q_cmd.restart = 1'b1;
            phase_in      = PH_ITEM;
            flag_bits_in  = '0;
            flag_index_in = 4'd8;
            ref_low_in    = '0;
            produced_in   = '0;
            stored_in     = '0;
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/core/lzsswd_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on lzsswd_pkg and the decoder's assertion macros.
`default_nettype none
`include "lzss_window_decoder_macros.svh"
module lzsswd_queue import lzsswd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      pop_cmd,
   output logic         empty
);
   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `LZSSWD_ASSERT(a_no_overflow, clock, reset, !(push && full), "push into full queue")
   `LZSSWD_ASSERT(a_no_underflow, clock, reset, !(pop && empty), "pop from empty queue")
endmodule
`default_nettype wire

/* rtl/core/lzsswd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lzsswd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

/* rtl/core/lzsswd_back.sv */
// Back end: runs commands, copies from the history RAM, sums and drives results.
// Depends on lzsswd_pkg, lzsswd_ram and the decoder's assertion macros.
`default_nettype none
`include "lzss_window_decoder_macros.svh"
module lzsswd_back import lzsswd_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  cmd_type      q_cmd,
   output logic         q_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_is_status,
   output logic [1:0]   rsp_status_code,
   output logic         rsp_last_of_run
);
   back_state_type      state_ff, state_in;
   cmd_type             cmd_ff, cmd_in;
   logic [CNT_W-1:0]    remain_ff, remain_in;
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [SUM_W-1:0]    usum_ff, usum_in;
   logic [SUM_W-1:0]    ssum_ff, ssum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff;
   logic                rsp_status_ff;
   logic [1:0]          rsp_code_ff;
   logic                rsp_last_ff;
   logic                out_free;
   logic                emit;
   logic [7:0]          emit_byte;
   logic                emit_status;
   logic [1:0]          emit_code;
   logic                emit_last;
   logic                wr_en;
   logic [7:0]          wr_data;
   logic                rd_en;
   logic [HIST_AW-1:0]  rd_addr;
   logic [7:0]          rd_data;
   logic                add_sum;
   logic                clear_sum;
   logic [7:0]          copy_byte;
   logic [1:0]          check_code;
   logic                after_main;

   lzsswd_ram #(
      .WIDTH (8),
      .DEPTH (HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[HIST_AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rd_addr    = pos_ff[HIST_AW-1:0] - cmd_ff.distance;
   // positions before the frame start read as space
   assign copy_byte  = (pos_ff < LEN_W'(cmd_ff.distance)) ? SPACE_BYTE : rd_data;
   assign check_code = (cmd_ff.stored == usum_ff || cmd_ff.stored == ssum_ff) ?
                       ST_OK : ST_BADSUM;
   assign after_main = cmd_ff.trunc;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      remain_in   = remain_ff;
      pos_in      = pos_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      emit_byte   = '0;
      emit_status = 1'b0;
      emit_code   = ST_OK;
      emit_last   = 1'b0;
      wr_en       = 1'b0;
      wr_data     = cmd_ff.data;
      rd_en       = 1'b0;
      add_sum     = 1'b0;
      clear_sum   = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               cmd_in    = q_cmd;
               remain_in = q_cmd.count;
               pos_in    = q_cmd.base;
               state_in  = BK_EXEC;
            end
         end
         BK_EXEC: begin
            unique case (cmd_ff.kind)
               CMD_LIT: begin
                  if (out_free) begin
                     emit      = 1'b1;
                     emit_byte = cmd_ff.data;
                     emit_last = !after_main;
                     wr_en     = 1'b1;
                     add_sum   = 1'b1;
                     clear_sum = cmd_ff.restart && !after_main;
                     state_in  = after_main ? BK_TAIL : BK_IDLE;
                  end
               end
               CMD_ZDIST, CMD_CHECK: begin
                  if (out_free) begin
                     emit        = 1'b1;
                     emit_status = 1'b1;
                     emit_code   = (cmd_ff.kind == CMD_ZDIST) ? ST_ZERODIST : check_code;
                     emit_last   = 1'b1;
                     clear_sum   = cmd_ff.restart;
                     state_in    = BK_IDLE;
                  end
               end
               CMD_COPY: begin
                  if (remain_ff != '0) begin
                     rd_en    = 1'b1;
                     state_in = BK_DATA;
                  end else begin
                     clear_sum = cmd_ff.restart && !after_main;
                     state_in  = after_main ? BK_TAIL : BK_IDLE;
                  end
               end
               default: begin
                  clear_sum = cmd_ff.restart && !after_main;
                  state_in  = after_main ? BK_TAIL : BK_IDLE;
               end
            endcase
         end
         BK_DATA: begin
            // read data is ready; hold it until the output register frees
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = copy_byte;
               emit_last = (remain_ff == CNT_W'(1)) && !after_main;
               wr_en     = 1'b1;
               wr_data   = copy_byte;
               add_sum   = 1'b1;
               pos_in    = pos_ff + LEN_W'(1);
               remain_in = remain_ff - CNT_W'(1);
               state_in  = BK_EXEC;
            end
         end
         BK_TAIL: begin
            if (out_free) begin
               emit        = 1'b1;
               emit_status = 1'b1;
               emit_code   = ST_TRUNC;
               emit_last   = 1'b1;
               clear_sum   = cmd_ff.restart;
               state_in    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
      if (add_sum && wr_en && pos_in == pos_ff) begin
         pos_in = pos_ff + LEN_W'(1);
      end
   end

   always_comb begin
      usum_in = usum_ff;
      ssum_in = ssum_ff;
      if (clear_sum) begin
         usum_in = '0;
         ssum_in = '0;
      end else if (add_sum) begin
         usum_in = usum_ff + SUM_W'(wr_data);
         ssum_in = ssum_ff + {{(SUM_W-8){wr_data[7]}}, wr_data};
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         usum_ff      <= '0;
         ssum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         usum_ff      <= usum_in;
         ssum_ff      <= ssum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      remain_ff <= remain_in;
      pos_ff    <= pos_in;
      if (emit) begin
         rsp_byte_ff   <= emit_byte;
         rsp_status_ff <= emit_status;
         rsp_code_ff   <= emit_code;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_is_status   = rsp_status_ff;
   assign rsp_status_code = rsp_code_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `LZSSWD_ASSERT(a_data_has_count, clock, reset, !(state_ff == BK_DATA) || (remain_ff != '0), "copy step with nothing left")
   `LZSSWD_ASSERT_NEXT(a_read_then_data, clock, reset, rd_en, state_ff == BK_DATA, "history read without data step")
   `LZSSWD_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid_ff, "emitted word not presented")
endmodule
`default_nettype wire

/* rtl/core/lzss_window_decoder.sv */
// LZSS decoder, 4096-byte history. A word passes through the command queue to the back
// end, which runs one command at a time: a literal is emitted from its execute state; a
// reference of n bytes, up to 18, steps through a RAM read and an emit for each byte.
// A two-entry command queue lets the parser run ahead; output stalls hold the back end.
// Reset (synchronous, active high) clears parser, queue, sums and output valid;
// the history RAM is not cleared; reads from before the frame start return space.
`default_nettype none
module lzss_window_decoder import lzsswd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [LEN_W-1:0]  csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_in_byte,
   input  wire logic              req_last_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_status,
   output logic [1:0]             rsp_status_code,
   output logic                   rsp_last_of_run
);
   logic     q_full;
   logic     q_push;
   logic     q_pop;
   logic     q_empty;
   cmd_type  push_cmd;
   cmd_type  pop_cmd;

   lzsswd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   lzsswd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   lzsswd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_is_status   (rsp_is_status),
      .rsp_status_code (rsp_status_code),
      .rsp_last_of_run (rsp_last_of_run)
   );
endmodule
`default_nettype wire
